// File: hdl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// Command and status codes, controller states and the control/status bundles.
// No dependencies.
`default_nettype none

package deq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int CMD_W          = 3;
	localparam int STATUS_W       = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_HEAD = 3'd0,
		CMD_PUSH_TAIL = 3'd1,
		CMD_POP_HEAD  = 3'd2,
		CMD_POP_TAIL  = 3'd3,
		CMD_PEEK_HEAD = 3'd4,
		CMD_PEEK_TAIL = 3'd5
	} deq_op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} deq_status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_HOLD = 1'b1
	} deq_state_t;

	// controller -> datapath
	typedef struct packed {
		logic        load;     // request taken this cycle
		logic        wr_en;    // store a word
		logic        wr_head;  // at head (else tail)
		logic        rd_en;    // fetch a word
		logic        rd_head;  // from head (else tail)
		logic        pop;      // remove the fetched word
		deq_status_t status;
	} deq_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic empty;
	} deq_stat_t;

endpackage

`default_nettype wire

// File: hdl/deq_in_if.sv
// Request channel: valid/ready handshake with command and data word.
// Depends on deq_pkg.
`default_nettype none

interface deq_in_if
	import deq_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
	logic                  valid;
	logic                  ready;
	logic [CMD_W-1:0]      cmd;
	logic [DATA_WIDTH-1:0] data_in;

	modport source (output valid, output cmd, output data_in, input ready);
	modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

`default_nettype wire

// File: hdl/deq_out_if.sv
// Result channel: valid/ready handshake with data, status, count and empty flag.
// Depends on deq_pkg.
`default_nettype none

interface deq_out_if
	import deq_pkg::*;
#(
	parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
	parameter int COUNT_WIDTH = $clog2(DEPTH_DEF + 1)
);
	logic                   valid;
	logic                   ready;
	logic [DATA_WIDTH-1:0]  data_out;
	logic [STATUS_W-1:0]    status;
	logic [COUNT_WIDTH-1:0] count;
	logic                   is_empty;

	modport source (output valid, output data_out, output status, output count,
		output is_empty, input ready);
	modport sink   (input valid, input data_out, input status, input count,
		input is_empty, output ready);
endinterface

`default_nettype wire

// File: hdl/deq_ctrl.sv
// Controller: decodes requests against full/empty and tracks the result slot.
// Depends on deq_pkg.
`default_nettype none

module deq_ctrl
	import deq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [CMD_W-1:0] in_cmd,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire deq_stat_t        stat,
	output deq_ctl_t              ctl
);

	deq_state_t state_q, state_d;
	logic       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		// result slot frees up in the same cycle it is taken
		in_ready  = (state_q == ST_IDLE) || out_ready;
		out_valid = (state_q == ST_HOLD);
		accept    = in_valid && in_ready;

		ctl         = '0;
		ctl.load    = accept;
		ctl.status  = STAT_OK;

		unique case (in_cmd)
			CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
				if (stat.full) begin
					ctl.status = STAT_FULL;
				end else begin
					ctl.wr_en   = accept;
					ctl.wr_head = (in_cmd == CMD_PUSH_HEAD);
				end
			end
			CMD_POP_HEAD, CMD_POP_TAIL, CMD_PEEK_HEAD, CMD_PEEK_TAIL: begin
				if (stat.empty) begin
					ctl.status = STAT_EMPTY;
				end else begin
					ctl.rd_en   = accept;
					ctl.rd_head = (in_cmd == CMD_POP_HEAD) || (in_cmd == CMD_PEEK_HEAD);
					ctl.pop     = accept &&
						((in_cmd == CMD_POP_HEAD) || (in_cmd == CMD_POP_TAIL));
				end
			end
			default: begin
				// unused codes: no change, status ok
			end
		endcase

		unique case (state_q)
			ST_IDLE: state_d = accept ? ST_HOLD : ST_IDLE;
			ST_HOLD: state_d = (accept || !out_ready) ? ST_HOLD : ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/deq_dp.sv
// Datapath: ring store, head/tail indexes, element count and result registers.
// Depends on deq_pkg; driven by deq_ctrl.
`default_nettype none

module deq_dp
	import deq_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int IDX_W     = $clog2(DEPTH),
	localparam int CNT_W     = $clog2(DEPTH + 1)
)(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire deq_ctl_t              ctl,
	input  wire logic [DATA_WIDTH-1:0] data_in,
	output deq_stat_t                  stat,
	output logic [DATA_WIDTH-1:0]      data_out,
	output logic [STATUS_W-1:0]        status,
	output logic [CNT_W-1:0]           count,
	output logic                       is_empty
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	logic [IDX_W-1:0]      head_q, tail_q;
	logic [CNT_W-1:0]      count_q, count_d;
	logic [IDX_W-1:0]      head_prev, head_next, tail_prev, tail_next;
	logic [IDX_W-1:0]      wr_addr, rd_addr;

	logic [DATA_WIDTH-1:0] rd_data_q;
	logic                  rd_ok_q;
	deq_status_t           status_q;
	logic [CNT_W-1:0]      out_count_q;
	logic                  out_empty_q;

	always_comb begin
		head_prev = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
		head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
		tail_prev = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;
		tail_next = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;

		wr_addr = ctl.wr_head ? head_prev : tail_q;
		rd_addr = ctl.rd_head ? head_q : tail_prev;

		count_d = count_q;
		if (ctl.wr_en) begin
			count_d = count_q + 1'b1;
		end else if (ctl.pop) begin
			count_d = count_q - 1'b1;
		end

		stat.full  = (count_q == FULL_CNT);
		stat.empty = (count_q == '0);
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= data_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			count_q <= count_d;
			if (ctl.wr_en && ctl.wr_head) begin
				head_q <= head_prev;
			end else if (ctl.pop && ctl.rd_head) begin
				head_q <= head_next;
			end
			if (ctl.wr_en && !ctl.wr_head) begin
				tail_q <= tail_next;
			end else if (ctl.pop && !ctl.rd_head) begin
				tail_q <= tail_prev;
			end
		end
	end

	// result slot, held until the next request is taken
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rd_ok_q     <= ctl.rd_en;
			status_q    <= ctl.status;
			out_count_q <= count_d;
			out_empty_q <= (count_d == '0);
		end
	end

	assign data_out = rd_ok_q ? rd_data_q : '0;
	assign status   = status_q;
	assign count    = out_count_q;
	assign is_empty = out_empty_q;

endmodule

`default_nettype wire

// File: hdl/double_ended_queue_top.sv
// Bounded double-ended queue: push/pop/peek at either end of a ring store.
// A result beat is presented in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; the single
// result register stalls intake only while an untaken result waits.
// Reset (arst_n, async, active low) empties the queue; no clearing pass.
// Depends on deq_pkg, deq_in_if, deq_out_if, deq_ctrl, deq_dp.
`default_nettype none

module double_ended_queue_top
	import deq_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
)(
	input  wire logic clk,
	input  wire logic arst_n,
	deq_in_if.sink    in_ch,
	deq_out_if.source out_ch
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	deq_ctl_t  ctl;
	deq_stat_t stat;
	logic [CNT_W-1:0] count;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_cmd    (in_ch.cmd),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	deq_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.data_in  (in_ch.data_in),
		.stat     (stat),
		.data_out (out_ch.data_out),
		.status   (out_ch.status),
		.count    (count),
		.is_empty (out_ch.is_empty)
	);

	assign out_ch.count = count;

endmodule

`default_nettype wire
